>>> rtl/core/lbpw_pkg.sv
package lbpw_pkg;

	localparam int unsigned NowW     = 32;
	localparam int unsigned PatW     = 3;
	localparam int unsigned ReqW     = 8;
	localparam int unsigned PeriodW  = 16;
	localparam int unsigned CfgIdxW  = 3;
	localparam int unsigned CfgDataW = 32;
	localparam int unsigned PhaseW   = 10;

	localparam logic [PatW-1:0]    TopPattern  = 3'd4;
	localparam logic [PhaseW-1:0]  BlinkOnMs   = 10'd100;
	localparam logic [PhaseW-1:0]  BlinkSlotMs = 10'd200;

	localparam logic [PatW-1:0]    NormalPatternRst = 3'd1;
	localparam logic [PeriodW-1:0] CyclePeriodRst   = 16'd1000;
	localparam logic [PeriodW-1:0] ToggleMsRst      = 16'd50;
	localparam logic [NowW-1:0]    GraceMsRst       = 32'd60000;

	typedef enum logic [CfgIdxW-1:0] {
		RegWdtEnabled    = 3'd0,
		RegNormalPattern = 3'd1,
		RegCyclePeriod   = 3'd2,
		RegToggleMs      = 3'd3,
		RegGraceMs       = 3'd4
	} cfg_reg_t;

	typedef enum logic {
		OpTick       = 1'b0,
		OpSetPattern = 1'b1
	} op_t;

	typedef struct packed {
		logic               gate_en;
		logic [PatW-1:0]    normal_pattern;
		logic [PeriodW-1:0] cycle_period_ms;
		logic [PeriodW-1:0] toggle_ms;
		logic [NowW-1:0]    grace_ms;
	} cfg_t;

	typedef struct packed {
		logic [PatW-1:0] pattern;
		logic            led_level;
		logic [NowW-1:0] toggle_start;
		logic [NowW-1:0] cycle_start;
		logic [NowW-1:0] grace_start;
	} state_t;

	typedef struct packed {
		logic            led_on;
		logic            feed_watchdog;
		logic [PatW-1:0] pattern_now;
	} result_t;

	// length of the blink phase of a cycle, 200 ms per blink
	function automatic logic [PhaseW-1:0] active_ms(input logic [PatW-1:0] pat);
		logic [PhaseW-1:0] r;
		begin
			case (pat)
				3'd1: r = 10'd200;
				3'd2: r = 10'd400;
				3'd3: r = 10'd600;
				3'd4: r = 10'd800;
				default: r = '0;
			endcase
			return r;
		end
	endfunction

endpackage

>>> rtl/core/lbpw_if.sv
interface lbpw_in_if;
	import lbpw_pkg::*;
	logic            valid;
	logic            ready;
	logic            op;
	logic [NowW-1:0] now_ms;
	logic [ReqW-1:0] new_pattern;
	modport source (output valid, output op, output now_ms, output new_pattern, input ready);
	modport sink (input valid, input op, input now_ms, input new_pattern, output ready);
endinterface

interface lbpw_out_if;
	import lbpw_pkg::*;
	logic            valid;
	logic            ready;
	logic            led_on;
	logic            feed_watchdog;
	logic [PatW-1:0] pattern_now;
	modport source (output valid, output led_on, output feed_watchdog, output pattern_now,
		input ready);
	modport sink (input valid, input led_on, input feed_watchdog, input pattern_now,
		output ready);
endinterface

interface lbpw_cfg_if;
	import lbpw_pkg::*;
	logic                valid;
	logic                ready;
	logic [CfgIdxW-1:0]  index;
	logic [CfgDataW-1:0] data;
	modport source (output valid, output index, output data, input ready);
	modport sink (input valid, input index, input data, output ready);
endinterface

>>> rtl/core/lbpw_step.sv
module lbpw_step (
	input  lbpw_pkg::cfg_t                    cfg,
	input  lbpw_pkg::state_t                  cur,
	input  logic                              op,
	input  logic [lbpw_pkg::NowW-1:0]         now_ms,
	input  logic [lbpw_pkg::ReqW-1:0]         new_pattern,
	output lbpw_pkg::state_t                  nxt,
	output lbpw_pkg::result_t                 res
);
	import lbpw_pkg::*;

	logic [NowW-1:0]   toggle_elapsed;
	logic [NowW-1:0]   cyc_age;
	logic [NowW-1:0]   grace_base;
	logic [NowW-1:0]   grace_elapsed;
	logic [PhaseW-1:0] phase;
	logic              in_active;
	logic              blink_on;
	logic              feed;

	assign toggle_elapsed = now_ms - cur.toggle_start;
	assign cyc_age        = now_ms - cur.cycle_start;
	// zero start time reads as not started
	assign grace_base     = (cur.grace_start == '0) ? now_ms : cur.grace_start;
	assign grace_elapsed  = now_ms - grace_base;

	assign in_active = cyc_age < {{(NowW-PhaseW){1'b0}}, active_ms(cur.pattern)};
	// only used while under 800 ms, so the low bits are enough
	assign phase     = cyc_age[PhaseW-1:0];
	assign blink_on  = (phase < BlinkOnMs)
		|| (phase >= BlinkSlotMs && phase < BlinkSlotMs + BlinkOnMs)
		|| (phase >= PhaseW'(2) * BlinkSlotMs && phase < PhaseW'(2) * BlinkSlotMs + BlinkOnMs)
		|| (phase >= PhaseW'(3) * BlinkSlotMs && phase < PhaseW'(3) * BlinkSlotMs + BlinkOnMs);

	always_comb begin
		nxt  = cur;
		feed = 1'b0;
		if (op_t'(op) == OpSetPattern) begin
			nxt.pattern      = (new_pattern > {{(ReqW-PatW){1'b0}}, TopPattern}) ?
				TopPattern : new_pattern[PatW-1:0];
			nxt.led_level    = 1'b0;
			nxt.toggle_start = now_ms;
			nxt.cycle_start  = now_ms;
		end else begin
			if (cfg.gate_en) begin
				if (cur.pattern == cfg.normal_pattern) begin
					nxt.grace_start = '0;
					feed            = 1'b1;
				end else begin
					nxt.grace_start = grace_base;
					feed            = grace_elapsed < cfg.grace_ms;
				end
			end
			if (cur.pattern == '0) begin
				if (toggle_elapsed >= {{(NowW-PeriodW){1'b0}}, cfg.toggle_ms}) begin
					nxt.led_level    = ~cur.led_level;
					nxt.toggle_start = now_ms;
				end
			end else if (in_active) begin
				nxt.led_level = blink_on;
			end else begin
				nxt.led_level = 1'b0;
				if (cyc_age >= {{(NowW-PeriodW){1'b0}}, cfg.cycle_period_ms})
					nxt.cycle_start = now_ms;
			end
		end
		res.led_on        = nxt.led_level;
		res.feed_watchdog = feed;
		res.pattern_now   = nxt.pattern;
	end

endmodule

>>> rtl/core/led_blink_pattern_watchdog.sv
// Status LED pattern generator with watchdog feed gate.
// items: one transfer per tick (op 0, now_ms) or pattern change (op 1, new_pattern).
// results: one transfer per item, in order: led_on, feed_watchdog, pattern_now.
// cfg: register writes (index 0..4), always ready; write only while the block is idle,
// indexes past the last register are ignored.
// Path: an accepted item goes to the input register, then its result to the result register.
// Throughput: one item per cycle while results does not stall; the state update (three 32-bit subtracts and
// compares) sits between the input register and the result register.
// Stall: while a held result is not taken the result register holds; the input register
// still fills, and items.ready drops only when both are occupied.
// Reset: registers return to defaults (gate off, normal pattern 1, cycle 1000 ms,
// toggle 50 ms, grace 60000 ms), pattern 0, LED off, timers zero, both stages empty.
module led_blink_pattern_watchdog (
	input logic        clk,
	input logic        arst_n,
	lbpw_in_if.sink    items,
	lbpw_out_if.source results,
	lbpw_cfg_if.sink   cfg
);
	import lbpw_pkg::*;

	cfg_t    cfg_q;
	state_t  state_q;
	state_t  state_nxt;
	result_t res_nxt;
	result_t res_q;

	logic              s1_valid_s1;
	logic              op_s1;
	logic [NowW-1:0]   now_ms_s1;
	logic [ReqW-1:0]   new_pattern_s1;
	logic              out_valid_q;
	logic              out_free;
	logic              adv;

	assign out_free    = !out_valid_q || results.ready;
	assign adv         = s1_valid_s1 && out_free;
	assign items.ready = !s1_valid_s1 || adv;
	assign cfg.ready   = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.gate_en         <= 1'b0;
			cfg_q.normal_pattern  <= NormalPatternRst;
			cfg_q.cycle_period_ms <= CyclePeriodRst;
			cfg_q.toggle_ms       <= ToggleMsRst;
			cfg_q.grace_ms        <= GraceMsRst;
		end else if (cfg.valid) begin
			case (cfg_reg_t'(cfg.index))
				RegWdtEnabled:    cfg_q.gate_en         <= cfg.data[0];
				RegNormalPattern: cfg_q.normal_pattern  <= cfg.data[PatW-1:0];
				RegCyclePeriod:   cfg_q.cycle_period_ms <= cfg.data[PeriodW-1:0];
				RegToggleMs:      cfg_q.toggle_ms       <= cfg.data[PeriodW-1:0];
				RegGraceMs:       cfg_q.grace_ms        <= cfg.data[NowW-1:0];
				default: ;
			endcase
		end
	end

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_s1 <= 1'b0;
		end else if (items.ready) begin
			s1_valid_s1 <= items.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (items.valid && items.ready) begin
			op_s1          <= items.op;
			now_ms_s1      <= items.now_ms;
			new_pattern_s1 <= items.new_pattern;
		end
	end

	lbpw_step u_step (
		.cfg         (cfg_q),
		.cur         (state_q),
		.op          (op_s1),
		.now_ms      (now_ms_s1),
		.new_pattern (new_pattern_s1),
		.nxt         (state_nxt),
		.res         (res_nxt)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q.pattern      <= '0;
			state_q.led_level    <= 1'b0;
			state_q.toggle_start <= '0;
			state_q.cycle_start  <= '0;
			state_q.grace_start  <= '0;
		end else if (adv) begin
			state_q <= state_nxt;
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_free) begin
			out_valid_q <= s1_valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv)
			res_q <= res_nxt;
	end

	assign results.valid         = out_valid_q;
	assign results.led_on        = res_q.led_on;
	assign results.feed_watchdog = res_q.feed_watchdog;
	assign results.pattern_now   = res_q.pattern_now;

	a_pattern_range: assert property (@(posedge clk) disable iff (!arst_n)
		state_q.pattern <= TopPattern)
		else $error("pattern register out of range");

	a_change_led_off: assert property (@(posedge clk) disable iff (!arst_n)
		adv && op_t'(op_s1) == OpSetPattern |=> !state_q.led_level && !res_q.feed_watchdog)
		else $error("pattern change left led on or fed watchdog");

	a_feed_needs_gate: assert property (@(posedge clk) disable iff (!arst_n)
		adv && res_nxt.feed_watchdog |-> cfg_q.gate_en)
		else $error("feed with gate disabled");

	a_stall_holds_s1: assert property (@(posedge clk) disable iff (!arst_n)
		s1_valid_s1 && !out_free |=> s1_valid_s1 && $stable(now_ms_s1))
		else $error("input register lost item under stall");

	a_take_fills_s1: assert property (@(posedge clk) disable iff (!arst_n)
		items.valid && items.ready |=> s1_valid_s1)
		else $error("accepted item not registered");

endmodule

>>> tb/sv/tb.sv
module tb;
	timeunit 1ns;
	timeprecision 1ps;
	import lbpw_pkg::*;

	localparam int unsigned HalfPeriod = 5;
	localparam int unsigned ResetCycles = 7;
	localparam int unsigned Phases = 8;
	localparam int unsigned ItemsPerPhase = 235;
	localparam int unsigned IdlePct = 37;
	localparam int unsigned SettleCycles = 4;
	localparam longint unsigned RunLimitNs = 5_000_000;
	localparam int unsigned NumRows = 31;

	localparam logic [NowW-1:0] SlotMs = 32'd200;
	localparam logic [NowW-1:0] OnMs = 32'd100;
	localparam logic [PatW-1:0] MaxPattern = 3'd4;
	localparam logic [CfgIdxW-1:0] RegUnused = 3'd7;

	typedef enum logic {RowItem, RowWrite} row_kind_t;
	typedef enum logic {ByPredictor, ByTable} row_check_t;

	typedef struct packed {
		row_kind_t           kind;
		op_t                 op;
		logic [NowW-1:0]     stamp;
		logic [ReqW-1:0]     req;
		logic [CfgIdxW-1:0]  reg_idx;
		logic [CfgDataW-1:0] wdata;
		row_check_t          check;
		logic                led;
		logic                feed;
		logic [PatW-1:0]     pat;
	} plan_row_t;

	logic clk = 1'b0;
	logic arst_n;
	bit   calm = 1'b0;
	int unsigned faults = 0;

	lbpw_in_if  items_bus ();
	lbpw_out_if res_bus ();
	lbpw_cfg_if cfg_bus ();

	led_blink_pattern_watchdog dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.items   (items_bus),
		.results (res_bus),
		.cfg     (cfg_bus)
	);

	// register copies, at their reset values
	logic               gate_on = 1'b0;
	logic [PatW-1:0]    healthy_pat = 3'd1;
	logic [PeriodW-1:0] cycle_len = 16'd1000;
	logic [PeriodW-1:0] half_period = 16'd50;
	logic [NowW-1:0]    grace_len = 32'd60000;

	// blinker and watchdog state
	logic [PatW-1:0] pat_now = '0;
	logic            led_lvl = 1'b0;
	logic [NowW-1:0] toggle_t0 = '0;
	logic [NowW-1:0] cycle_t0 = '0;
	logic [NowW-1:0] grace_t0 = '0;
	logic            feeding = 1'b1;

	result_t due_results[$];
	result_t due;

	plan_row_t plan [NumRows] = '{
		'{RowItem,  OpTick,       32'd0,          8'd0,   '0,            '0,
			ByTable, 1'b0, 1'b0, 3'd0},
		'{RowItem,  OpTick,       32'd50,         8'd0,   '0,            '0,
			ByTable, 1'b1, 1'b0, 3'd0},
		'{RowItem,  OpTick,       32'd100,        8'd0,   '0,            '0,
			ByTable, 1'b0, 1'b0, 3'd0},
		'{RowItem,  OpSetPattern, 32'd1000,       8'd255, '0,            '0,
			ByTable, 1'b0, 1'b0, 3'd4},
		'{RowItem,  OpTick,       32'd1050,       8'd0,   '0,            '0,
			ByTable, 1'b1, 1'b0, 3'd4},
		'{RowItem,  OpTick,       32'd1150,       8'd0,   '0,            '0,
			ByTable, 1'b0, 1'b0, 3'd4},
		'{RowItem,  OpTick,       32'd2000,       8'd0,   '0,            '0,
			ByTable, 1'b0, 1'b0, 3'd4},
		'{RowItem,  OpTick,       32'd2000,       8'd0,   '0,            '0,
			ByTable, 1'b1, 1'b0, 3'd4},
		'{RowItem,  OpSetPattern, 32'hFFFF_FFF0,  8'd1,   '0,            '0,
			ByTable, 1'b0, 1'b0, 3'd1},
		// timestamp wraps inside the first blink
		'{RowItem,  OpTick,       32'h0000_0010,  8'd0,   '0,            '0,
			ByTable, 1'b1, 1'b0, 3'd1},
		'{RowItem,  OpSetPattern, 32'h0000_0060,  8'd5,   '0,            '0,
			ByTable, 1'b0, 1'b0, 3'd4},
		'{RowItem,  OpSetPattern, 32'hFFFF_FFFF,  8'd0,   '0,            '0,
			ByTable, 1'b0, 1'b0, 3'd0},
		'{RowWrite, OpTick,       '0,             '0,     RegWdtEnabled, 32'd1,
			ByPredictor, 1'b0, 1'b0, 3'd0},
		'{RowWrite, OpTick,       '0,             '0,     RegUnused,     32'hFFFF_FFFF,
			ByPredictor, 1'b0, 1'b0, 3'd0},
		'{RowWrite, OpTick,       '0,             '0,     RegGraceMs,    32'd100,
			ByPredictor, 1'b0, 1'b0, 3'd0},
		'{RowWrite, OpTick,       '0,             '0,     RegToggleMs,   32'd0,
			ByPredictor, 1'b0, 1'b0, 3'd0},
		// zero toggle period: flips on every tick
		'{RowItem,  OpTick,       32'd5000,       8'd0,   '0,            '0,
			ByPredictor, 1'b0, 1'b0, 3'd0},
		'{RowItem,  OpTick,       32'd5000,       8'd0,   '0,            '0,
			ByTable, 1'b0, 1'b1, 3'd0},
		'{RowItem,  OpTick,       32'd5100,       8'd0,   '0,            '0,
			ByTable, 1'b1, 1'b0, 3'd0},
		'{RowItem,  OpSetPattern, 32'd6000,       8'd1,   '0,            '0,
			ByTable, 1'b0, 1'b0, 3'd1},
		'{RowItem,  OpTick,       32'd6000,       8'd0,   '0,            '0,
			ByTable, 1'b1, 1'b1, 3'd1},
		'{RowItem,  OpSetPattern, 32'd0,          8'd0,   '0,            '0,
			ByTable, 1'b0, 1'b0, 3'd0},
		// grace timer started at time zero reads as not started
		'{RowItem,  OpTick,       32'd0,          8'd0,   '0,            '0,
			ByTable, 1'b1, 1'b1, 3'd0},
		'{RowItem,  OpTick,       32'd150,        8'd0,   '0,            '0,
			ByTable, 1'b0, 1'b1, 3'd0},
		'{RowItem,  OpTick,       32'd250,        8'd0,   '0,            '0,
			ByTable, 1'b1, 1'b0, 3'd0},
		'{RowWrite, OpTick,       '0,             '0,     RegNormalPattern, 32'd7,
			ByPredictor, 1'b0, 1'b0, 3'd0},
		'{RowWrite, OpTick,       '0,             '0,     RegCyclePeriod, 32'd0,
			ByPredictor, 1'b0, 1'b0, 3'd0},
		'{RowItem,  OpSetPattern, 32'd300,        8'd3,   '0,            '0,
			ByTable, 1'b0, 1'b0, 3'd3},
		'{RowItem,  OpTick,       32'd300,        8'd0,   '0,            '0,
			ByPredictor, 1'b0, 1'b0, 3'd0},
		// zero cycle period restarts as soon as the blinks are over
		'{RowItem,  OpTick,       32'd900,        8'd0,   '0,            '0,
			ByTable, 1'b0, 1'b0, 3'd3},
		'{RowItem,  OpTick,       32'd950,        8'd0,   '0,            '0,
			ByTable, 1'b1, 1'b0, 3'd3}
	};

	always #(HalfPeriod) clk = ~clk;

	function automatic result_t step_blinker(input op_t op, input logic [NowW-1:0] stamp,
			input logic [ReqW-1:0] req);
		logic [NowW-1:0] since;
		logic [NowW-1:0] blink_span;
		result_t r;
		r = '0;
		if (op == OpSetPattern) begin
			pat_now = (req > ReqW'(MaxPattern)) ? MaxPattern : req[PatW-1:0];
			led_lvl = 1'b0;
			toggle_t0 = stamp;
			cycle_t0 = stamp;
		end else begin
			if (gate_on) begin
				if (pat_now == healthy_pat) begin
					grace_t0 = '0;
					feeding = 1'b1;
				end else begin
					if (grace_t0 == '0)
						grace_t0 = stamp;
					since = stamp - grace_t0;
					feeding = (since < grace_len);
				end
				r.feed_watchdog = feeding;
			end
			if (pat_now == '0) begin
				since = stamp - toggle_t0;
				if (since >= NowW'(half_period)) begin
					led_lvl = ~led_lvl;
					toggle_t0 = stamp;
				end
			end else begin
				since = stamp - cycle_t0;
				blink_span = NowW'(pat_now) * SlotMs;
				if (since < blink_span) begin
					led_lvl = (since % SlotMs) < OnMs;
				end else begin
					led_lvl = 1'b0;
					if (since >= NowW'(cycle_len))
						cycle_t0 = stamp;
				end
			end
		end
		r.led_on = led_lvl;
		r.pattern_now = pat_now;
		return r;
	endfunction

	task automatic flag_mismatch(input string msg);
		faults++;
		$display("%0t ns: mismatch: %s", $time, msg);
	endtask

	task automatic send_item(input op_t op, input logic [NowW-1:0] stamp,
			input logic [ReqW-1:0] req, input row_check_t check, input result_t table_res);
		result_t predicted;
		if (!calm && $urandom_range(99) < IdlePct) begin
			items_bus.valid <= 1'b0;
			repeat ($urandom_range(1, 4)) @(posedge clk);
		end
		items_bus.valid <= 1'b1;
		items_bus.op <= op;
		items_bus.now_ms <= stamp;
		items_bus.new_pattern <= req;
		do @(posedge clk); while (items_bus.ready !== 1'b1);
		predicted = step_blinker(op, stamp, req);
		due_results.push_back((check == ByTable) ? table_res : predicted);
	endtask

	task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [CfgDataW-1:0] data);
		cfg_bus.valid <= 1'b1;
		cfg_bus.index <= idx;
		cfg_bus.data <= data;
		do @(posedge clk); while (cfg_bus.ready !== 1'b1);
		case (idx)
			RegWdtEnabled:    gate_on = data[0];
			RegNormalPattern: healthy_pat = data[PatW-1:0];
			RegCyclePeriod:   cycle_len = data[PeriodW-1:0];
			RegToggleMs:      half_period = data[PeriodW-1:0];
			RegGraceMs:       grace_len = data;
			default: ;
		endcase
	endtask

	// stop feeding items and let the pipeline empty out
	task automatic drain_block();
		items_bus.valid <= 1'b0;
		while (due_results.size() != 0)
			@(posedge clk);
		repeat (SettleCycles) @(posedge clk);
	endtask

	always @(posedge clk) begin
		res_bus.ready <= calm || ($urandom_range(99) >= IdlePct);
	end

	always @(posedge clk) begin
		if (arst_n && res_bus.valid && res_bus.ready) begin
			if (due_results.size() == 0) begin
				flag_mismatch("result transfer with nothing outstanding");
			end else begin
				due = due_results.pop_front();
				if (res_bus.led_on !== due.led_on)
					flag_mismatch($sformatf("led_on got %b want %b", res_bus.led_on,
						due.led_on));
				if (res_bus.feed_watchdog !== due.feed_watchdog)
					flag_mismatch($sformatf("feed_watchdog got %b want %b",
						res_bus.feed_watchdog, due.feed_watchdog));
				if (res_bus.pattern_now !== due.pattern_now)
					flag_mismatch($sformatf("pattern_now got %0d want %0d",
						res_bus.pattern_now, due.pattern_now));
			end
		end
	end

	initial begin
		#(RunLimitNs);
		$display("[FAIL] regression broken");
		$finish;
	end

	initial begin
		int unsigned i;
		int unsigned ph;
		int unsigned n;
		int unsigned roll;
		op_t op;
		logic [NowW-1:0] clock_ms;
		logic [ReqW-1:0] req;
		logic batch_open;
		logic gate_v;
		logic [PatW-1:0] norm_v;
		logic [PeriodW-1:0] cyc_v;
		logic [PeriodW-1:0] tog_v;
		logic [NowW-1:0] grace_v;

		arst_n = 1'b0;
		items_bus.valid = 1'b0;
		items_bus.op = OpTick;
		items_bus.now_ms = '0;
		items_bus.new_pattern = '0;
		cfg_bus.valid = 1'b0;
		cfg_bus.index = RegWdtEnabled;
		cfg_bus.data = '0;
		batch_open = 1'b0;

		repeat (ResetCycles) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		for (i = 0; i < NumRows; i++) begin
			if (plan[i].kind == RowWrite) begin
				if (!batch_open)
					drain_block();
				batch_open = 1'b1;
				write_reg(plan[i].reg_idx, plan[i].wdata);
			end else begin
				if (batch_open)
					cfg_bus.valid <= 1'b0;
				batch_open = 1'b0;
				send_item(plan[i].op, plan[i].stamp, plan[i].req, plan[i].check,
					{plan[i].led, plan[i].feed, plan[i].pat});
			end
		end

		for (ph = 0; ph < Phases; ph++) begin
			drain_block();
			case (ph)
				0: begin
					gate_v = 1'b1; norm_v = 3'd1; cyc_v = 16'd1000; tog_v = 16'd50;
					grace_v = 32'd300;
				end
				1: begin
					gate_v = 1'b0; norm_v = 3'd0; cyc_v = 16'd0; tog_v = 16'd0;
					grace_v = 32'd0;
				end
				2: begin
					gate_v = 1'b1; norm_v = 3'd7; cyc_v = 16'hFFFF; tog_v = 16'hFFFF;
					grace_v = 32'hFFFF_FFFF;
				end
				3: begin
					gate_v = 1'b1; norm_v = 3'd4; cyc_v = 16'd1; tog_v = 16'd1;
					grace_v = 32'd0;
				end
				default: begin
					gate_v = 1'($urandom_range(1));
					norm_v = 3'($urandom_range(7));
					cyc_v = 16'($urandom_range(2000));
					tog_v = 16'($urandom_range(300));
					grace_v = 32'($urandom_range(3000));
				end
			endcase
			write_reg(RegWdtEnabled, 32'(gate_v));
			write_reg(RegNormalPattern, 32'(norm_v));
			write_reg(RegCyclePeriod, 32'(cyc_v));
			write_reg(RegToggleMs, 32'(tog_v));
			write_reg(RegGraceMs, grace_v);
			cfg_bus.valid <= 1'b0;
			// one phase runs with both sides flat out
			calm <= (ph == 3);
			clock_ms = $urandom();

			for (n = 0; n < ItemsPerPhase; n++) begin
				roll = $urandom_range(99);
				if (roll < 9) begin
					op = OpSetPattern;
					if ($urandom_range(3) == 0)
						req = 8'($urandom_range(255));
					else
						req = 8'($urandom_range(4));
				end else begin
					op = OpTick;
					req = 8'($urandom_range(255));
					roll = $urandom_range(99);
					// mostly a steady clock, now and then a jump, a wrap or time zero
					if (roll < 2)
						clock_ms = $urandom();
					else if (roll < 3)
						clock_ms = '0;
					else if (roll < 4)
						clock_ms = 32'hFFFF_FF00 + 32'($urandom_range(255));
					else if (roll < 9)
						clock_ms += 32'($urandom_range(2000));
					else
						clock_ms += 32'($urandom_range(60));
				end
				send_item(op, clock_ms, req, ByPredictor, '0);
			end
		end

		calm <= 1'b0;
		drain_block();
		repeat (2 * SettleCycles) @(posedge clk);
		if (faults == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end

endmodule
